>>> hdl/ipw_pkg.sv
// Shared constants and types for the infrared pulse-width bit transmitter.
package ipw_pkg;

   localparam int DATA_WIDTH  = 16;
   localparam int COUNT_WIDTH = 8;
   localparam int LEAD_TICKS  = 2;

   localparam int REG_WIDTH   = 8;
   localparam int IN_DATA_W   = 16;
   localparam int IN_COUNT_W  = 5;
   localparam int BITS_W      = $clog2(DATA_WIDTH + 1);
   localparam int POS_W       = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

   localparam int ADDR_W      = 4;
   localparam int PDATA_W     = 32;

   localparam logic [ADDR_W-1:0] ADDR_ONE_WIDTH  = ADDR_W'(0);
   localparam logic [ADDR_W-1:0] ADDR_ZERO_WIDTH = ADDR_W'(4);
   localparam logic [ADDR_W-1:0] ADDR_GAP        = ADDR_W'(8);

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_START = 1'b1;

   typedef struct packed {
      logic [REG_WIDTH-1:0] one_pulse_width;
      logic [REG_WIDTH-1:0] zero_pulse_width;
      logic [REG_WIDTH-1:0] gap_cycles;
   } ipw_cfg_type;

   typedef struct packed {
      logic accepted;
      logic mod_level;
      logic busy_res;
      logic done_res;
   } ipw_result_type;

endpackage

>>> hdl/ipw_csr.sv
// Configuration register file with an APB-style access port.
module ipw_csr
   import ipw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [ADDR_W-1:0]  paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready,
   output ipw_cfg_type        cfg
);

   ipw_cfg_type cfg_ff;
   ipw_cfg_type cfg_in;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr)
            ADDR_ONE_WIDTH:  cfg_in.one_pulse_width  = pwdata[REG_WIDTH-1:0];
            ADDR_ZERO_WIDTH: cfg_in.zero_pulse_width = pwdata[REG_WIDTH-1:0];
            ADDR_GAP:        cfg_in.gap_cycles       = pwdata[REG_WIDTH-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.one_pulse_width  <= REG_WIDTH'(20);
         cfg_ff.zero_pulse_width <= REG_WIDTH'(10);
         cfg_ff.gap_cycles       <= REG_WIDTH'(10);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (paddr)
         ADDR_ONE_WIDTH:  prdata = PDATA_W'(cfg_ff.one_pulse_width);
         ADDR_ZERO_WIDTH: prdata = PDATA_W'(cfg_ff.zero_pulse_width);
         ADDR_GAP:        prdata = PDATA_W'(cfg_ff.gap_cycles);
         default:         prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> hdl/ipw_core.sv
// Transmit sequencer state and its single-pass next-state and result logic.
module ipw_core
   import ipw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  cmd,
   input  logic [IN_DATA_W-1:0]  data,
   input  logic [IN_COUNT_W-1:0] bit_count,
   input  ipw_cfg_type           cfg,
   output ipw_result_type        result
);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_LEAD  = 2'd1;
   localparam logic [1:0] PH_PULSE = 2'd2;
   localparam logic [1:0] PH_GAP   = 2'd3;

   logic [DATA_WIDTH-1:0]  shift_word_ff, shift_word_in;
   logic [BITS_W-1:0]      bits_left_ff, bits_left_in;
   logic [COUNT_WIDTH-1:0] segment_ticks_ff, segment_ticks_in;
   logic [1:0]             phase_ff, phase_in;
   logic                   level_ff, level_in;

   logic                   accepted;
   logic                   done;
   logic [BITS_W-1:0]      count_sat;
   logic [BITS_W-1:0]      bits_dec;
   logic [POS_W-1:0]       pos;
   logic                   cur_bit;
   logic [REG_WIDTH-1:0]   gap_m1;

   always_comb begin
      if (5'(bit_count) > 5'(DATA_WIDTH) && DATA_WIDTH < 32) begin
         count_sat = BITS_W'(DATA_WIDTH);
      end else begin
         count_sat = BITS_W'(bit_count);
      end
   end

   assign bits_dec = bits_left_ff - BITS_W'(1);
   assign pos      = POS_W'(bits_dec);
   assign cur_bit  = shift_word_ff[pos];
   assign gap_m1   = (cfg.gap_cycles == '0) ? '0 : cfg.gap_cycles - REG_WIDTH'(1);

   always_comb begin
      shift_word_in    = shift_word_ff;
      bits_left_in     = bits_left_ff;
      segment_ticks_in = segment_ticks_ff;
      phase_in         = phase_ff;
      level_in         = level_ff;
      accepted         = 1'b0;
      done             = 1'b0;
      if (cmd == CMD_START) begin
         if (phase_ff == PH_IDLE) begin
            accepted = 1'b1;
            level_in = 1'b0;
            if (count_sat == '0) begin
               done = 1'b1;
            end else begin
               shift_word_in    = DATA_WIDTH'(data);
               bits_left_in     = count_sat;
               segment_ticks_in = COUNT_WIDTH'(LEAD_TICKS - 1);
               phase_in         = PH_LEAD;
            end
         end
      end else if (phase_ff != PH_IDLE) begin
         if (segment_ticks_ff != '0) begin
            segment_ticks_in = segment_ticks_ff - COUNT_WIDTH'(1);
         end else if (phase_ff == PH_PULSE) begin
            bits_left_in = bits_dec;
            level_in     = 1'b0;
            if (bits_dec == '0) begin
               phase_in = PH_IDLE;
               done     = 1'b1;
            end else begin
               segment_ticks_in = COUNT_WIDTH'(gap_m1);
               phase_in         = PH_GAP;
            end
         end else begin
            segment_ticks_in = cur_bit ? COUNT_WIDTH'(cfg.one_pulse_width)
                                       : COUNT_WIDTH'(cfg.zero_pulse_width);
            phase_in         = PH_PULSE;
            level_in         = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_word_ff    <= '0;
         bits_left_ff     <= '0;
         segment_ticks_ff <= '0;
         phase_ff         <= PH_IDLE;
         level_ff         <= 1'b0;
      end else if (step) begin
         shift_word_ff    <= shift_word_in;
         bits_left_ff     <= bits_left_in;
         segment_ticks_ff <= segment_ticks_in;
         phase_ff         <= phase_in;
         level_ff         <= level_in;
      end
   end

   assign result.accepted  = accepted;
   assign result.mod_level = level_in;
   assign result.busy_res  = (phase_in != PH_IDLE);
   assign result.done_res  = done;

endmodule

>>> hdl/ir_pulse_width_bit_transmitter_top.sv
// Top level of the infrared pulse-width bit transmitter.
//
// The request channel (req_valid, req_ready) carries one word per carrier tick
// or start command: req_cmd, req_data and req_bit_count. Every request word
// produces exactly one response word on the rsp_ channel with the accepted,
// modulation level, busy and done flags that hold after that word.
// A request word is captured in an input register and evaluated in one pass
// against the sequencer state; the response is captured in an output register.
// rsp_valid rises once the captured word advances into the output register,
// so a response passes the input and then the output register, and one word
// is taken per cycle as long as the response side keeps up.
// When the receiver stalls, the output register holds its word, the input
// register holds the next one, and req_ready drops until the output drains.
// Pulse widths and the gap length are set through the APB-style port, which
// is always ready; writes are expected only while the block is idle.
// A synchronous reset empties both registers, returns the sequencer to idle
// with the envelope low and restores the default register values.
module ir_pulse_width_bit_transmitter_top
   import ipw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_cmd,
   input  logic [IN_DATA_W-1:0]  req_data,
   input  logic [IN_COUNT_W-1:0] req_bit_count,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_accepted,
   output logic                  rsp_mod_level,
   output logic                  rsp_busy_res,
   output logic                  rsp_done_res,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_W-1:0]     paddr,
   input  logic [PDATA_W-1:0]    pwdata,
   output logic [PDATA_W-1:0]    prdata,
   output logic                  pready
);

   ipw_cfg_type           cfg;
   ipw_result_type        core_result;
   ipw_result_type        result_ff;
   logic                  in_vld_ff;
   logic                  out_vld_ff;
   logic                  cmd_ff;
   logic [IN_DATA_W-1:0]  data_ff;
   logic [IN_COUNT_W-1:0] count_ff;
   logic                  advance;
   logic                  load_in;

   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign load_in   = req_valid && req_ready;

   ipw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ipw_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .cmd       (cmd_ff),
      .data      (data_ff),
      .bit_count (count_ff),
      .cfg       (cfg),
      .result    (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (load_in) begin
         in_vld_ff <= 1'b1;
      end else if (advance) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         cmd_ff   <= req_cmd;
         data_ff  <= req_data;
         count_ff <= req_bit_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= core_result;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_accepted  = result_ff.accepted;
   assign rsp_mod_level = result_ff.mod_level;
   assign rsp_busy_res  = result_ff.busy_res;
   assign rsp_done_res  = result_ff.done_res;

endmodule
